### hw/rtl/csw_pkg.sv
// Shared types, constants and segment encoding for the countdown stopwatch.
package csw_pkg;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_RUN       = 3'd1,
        CMD_STOP      = 3'd2,
        CMD_DISP_ON   = 3'd3,
        CMD_DISP_OFF  = 3'd4,
        CMD_SET_ALL   = 3'd5,
        CMD_SET_SEC   = 3'd6,
        CMD_SET_HUND  = 3'd7
    } csw_cmd_t;

    localparam int unsigned TimeW = 7;

    localparam logic [TimeW-1:0] MinuteReset    = 7'd59;
    localparam logic [TimeW-1:0] SecondReset    = 7'd59;
    localparam logic [TimeW-1:0] HundredthReset = 7'd99;
    localparam logic [TimeW-1:0] SecondWrap     = 7'd59;
    localparam logic [TimeW-1:0] HundredthWrap  = 7'd99;

    localparam int unsigned InDataW  = 24;
    localparam int unsigned OutDataW = 72;

    typedef struct packed {
        logic [TimeW-1:0] minute_count;
        logic [TimeW-1:0] second_count;
        logic [TimeW-1:0] hundredth_count;
        logic             run_request;
        logic             display_enable;
        logic             count_active;
        logic             tick_enable;
        logic [15:0]      shown_high;
        logic [31:0]      shown_low;
    } csw_state_t;

    // Seven-segment code of one decimal digit; digits above nine stay dark.
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

### hw/rtl/csw_disp.sv
// Splits the time into decimal digits and encodes the segment words.
module csw_disp (
    input  logic [csw_pkg::TimeW-1:0] minutes,
    input  logic [csw_pkg::TimeW-1:0] seconds,
    input  logic [csw_pkg::TimeW-1:0] hundredths,
    output logic [15:0]               word_high,
    output logic [31:0]               word_low
);
    import csw_pkg::*;

    logic [TimeW-1:0] vals [3];
    logic [15:0]      pairs [3];

    assign vals[0] = minutes;
    assign vals[1] = seconds;
    assign vals[2] = hundredths;

    // tens = (v * 205) >> 11 is exact for every 7-bit value
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [14:0] prod;
            logic [3:0]  tens;
            logic [6:0]  units;
            prod  = {8'd0, vals[i]} * 15'd205;
            tens  = prod[14:11];
            units = 7'(vals[i] - 7'({3'd0, tens} * 7'd10));
            pairs[i] = {seg_code(tens), seg_code(units[3:0])};
        end
    end

    assign word_high = pairs[0];
    assign word_low  = {pairs[1], pairs[2]};

endmodule

### hw/rtl/csw_step.sv
// Next-state logic for one tick or command item.
module csw_step (
    input  csw_pkg::csw_state_t           cur,
    input  csw_pkg::csw_cmd_t             cmd,
    input  logic [csw_pkg::TimeW-1:0]     new_minutes,
    input  logic [csw_pkg::TimeW-1:0]     new_seconds,
    input  logic [csw_pkg::TimeW-1:0]     new_hundredths,
    output csw_pkg::csw_state_t           nxt
);
    import csw_pkg::*;

    csw_state_t       pre;
    logic             refresh;
    logic             blank;
    logic [15:0]      word_high;
    logic [31:0]      word_low;

    // Update time and flags; the words are settled afterwards
    always_comb begin
        pre     = cur;
        refresh = 1'b0;
        blank   = 1'b0;
        if (cmd == CMD_TICK) begin
            if (cur.tick_enable) begin
                refresh = 1'b1;
                if (!cur.run_request) begin
                    pre.tick_enable  = 1'b0;
                    pre.count_active = 1'b0;
                end
                if (pre.count_active) begin
                    if (cur.hundredth_count != '0) begin
                        pre.hundredth_count = 7'(cur.hundredth_count - 7'd1);
                    end else if (cur.second_count != '0) begin
                        pre.hundredth_count = HundredthWrap;
                        pre.second_count    = 7'(cur.second_count - 7'd1);
                    end else if (cur.minute_count != '0) begin
                        pre.hundredth_count = HundredthWrap;
                        pre.second_count    = SecondWrap;
                        pre.minute_count    = 7'(cur.minute_count - 7'd1);
                    end else begin
                        // borrow out of zero: hold zero and stop ticking
                        pre.hundredth_count = '0;
                        pre.second_count    = '0;
                        pre.minute_count    = '0;
                        pre.tick_enable     = 1'b0;
                    end
                end
            end
        end else begin
            case (cmd)
                CMD_RUN:  pre.run_request = 1'b1;
                CMD_STOP: pre.run_request = 1'b0;
                CMD_DISP_ON: begin
                    pre.display_enable = 1'b1;
                    refresh            = 1'b1;
                end
                CMD_DISP_OFF: begin
                    pre.display_enable = 1'b0;
                    blank              = 1'b1;
                end
                CMD_SET_ALL: begin
                    pre.minute_count    = new_minutes;
                    pre.second_count    = new_seconds;
                    pre.hundredth_count = new_hundredths;
                    refresh             = 1'b1;
                end
                CMD_SET_SEC: begin
                    pre.second_count = new_seconds;
                    refresh          = 1'b1;
                end
                CMD_SET_HUND: begin
                    pre.hundredth_count = new_hundredths;
                    refresh             = 1'b1;
                end
                default: ;
            endcase
            if (pre.run_request) begin
                pre.tick_enable  = 1'b1;
                pre.count_active = 1'b1;
            end
        end
    end

    csw_disp u_disp (
        .minutes    (pre.minute_count),
        .seconds    (pre.second_count),
        .hundredths (pre.hundredth_count),
        .word_high  (word_high),
        .word_low   (word_low)
    );

    always_comb begin
        nxt = pre;
        if (blank) begin
            nxt.shown_high = '0;
            nxt.shown_low  = '0;
        end else if (refresh && pre.display_enable) begin
            nxt.shown_high = word_high;
            nxt.shown_low  = word_low;
        end
    end

endmodule

### hw/rtl/countdown_stopwatch_seven_segment_top.sv
// Top level of the countdown stopwatch with seven-segment output words.
//
// Usage: each item on the s_ channel is a tick or a command. s_tuser carries
// the command code (tick, run, stop, display on/off, set all, set seconds,
// set hundredths); s_tdata carries the new minutes, seconds and hundredths
// used by the set commands. Every item yields exactly one result item on the
// m_ channel: the shown segment words, the time after the item and the
// counting and ticking flags.
//
// Pipeline: an item is captured in an input register, the step logic works on
// it from there and its result lands in the output register, from which it is
// offered on the m_ channel. Throughput: one item per cycle while results are
// taken, set by the single pass through the step logic; the time state
// updates in that pass.
//
// Reset (aresetn low, synchronous): time goes to 59:59:99, run, display,
// counting and ticking are set, the words are cleared and both stages empty.
// Stall: while m_tready is low a held result keeps its output register; the
// input register still takes one more item, then s_tready drops until the
// result is taken.
module countdown_stopwatch_seven_segment_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // new_minutes[6:0], new_seconds[13:7], new_hundredths[20:14], zero pad
    input  logic [csw_pkg::InDataW-1:0]   s_tdata,
    // command[2:0]
    input  logic [2:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hex_high[15:0], hex_low[47:16], minutes[54:48], seconds[61:55],
    // hundredths[68:62], counting[69], ticking[70], zero pad
    output logic [csw_pkg::OutDataW-1:0]  m_tdata
);
    import csw_pkg::*;

    // input stage
    logic                    in_valid_reg;
    csw_cmd_t                in_cmd_reg;
    logic [3*TimeW-1:0]      in_time_reg;

    // persistent stopwatch state
    csw_state_t              state_reg;
    csw_state_t              state_next;

    // result stage
    logic                    out_valid_reg;
    csw_state_t              out_reg;

    logic                    advance;

    // advance the input stage when the result stage is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    csw_step u_step (
        .cur            (state_reg),
        .cmd            (in_cmd_reg),
        .new_minutes    (in_time_reg[TimeW-1:0]),
        .new_seconds    (in_time_reg[2*TimeW-1:TimeW]),
        .new_hundredths (in_time_reg[3*TimeW-1:2*TimeW]),
        .nxt            (state_next)
    );

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
            state_reg.minute_count    <= MinuteReset;
            state_reg.second_count    <= SecondReset;
            state_reg.hundredth_count <= HundredthReset;
            state_reg.run_request     <= 1'b1;
            state_reg.display_enable  <= 1'b1;
            state_reg.count_active    <= 1'b1;
            state_reg.tick_enable     <= 1'b1;
            state_reg.shown_high      <= '0;
            state_reg.shown_low       <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: input on acceptance, result on advance, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= csw_cmd_t'(s_tuser);
            in_time_reg <= s_tdata[3*TimeW-1:0];
        end
        if (advance) begin
            out_reg <= state_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_reg.tick_enable,
                       out_reg.count_active,
                       out_reg.hundredth_count,
                       out_reg.second_count,
                       out_reg.minute_count,
                       out_reg.shown_low,
                       out_reg.shown_high};

endmodule
